// File: sv/fixed_timestep_accumulator_defines.svh
// assertion macros used by the accumulator rtl file
`ifndef FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH

// checked only outside reset
`define FTA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FTA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/fta_pkg.sv
`default_nettype none

package fta_pkg;

  localparam int unsigned AccWidthDef = 48;

  localparam logic [31:0] StepLengthRst = 32'd16667;
  localparam logic [7:0]  MaxStepsRst   = 8'd8;
  localparam logic [31:0] TimeScaleRst  = 32'd65536;
  localparam logic        PauseRst      = 1'b0;
  localparam logic [63:0] EpochRst      = 64'd0;

  localparam logic [16:0] AlphaOne = 17'd65536;

  typedef enum logic [2:0] {
    REG_STEP_LENGTH = 3'd0,
    REG_MAX_STEPS   = 3'd1,
    REG_TIME_SCALE  = 3'd2,
    REG_PAUSE       = 3'd3,
    REG_EPOCH       = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_STEP    = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: sv/fixed_timestep_accumulator.sv
// Fixed-timestep simulation clock. An advance item scales elapsed real time by a Q16.16
// factor, adds it (rounded, saturating) to the leftover accumulator, then takes whole fixed
// steps, up to max_steps_per_advance. A step item adds forced_steps steps to fixed time.
// Each item returns one result: steps taken, fixed time, render time and the interpolation
// alpha in Q1.16. Work runs on one shared multiplier, one compare/subtract step loop and a
// restoring divider, one item at a time. An advance item takes longer the more steps it
// takes, and both kinds of item finish sooner when alpha needs no division (zero step
// length, or a leftover of at least one step). The step loop takes one step per cycle, the
// alpha divider gives one quotient bit per cycle, and the next item is taken in the cycle
// after the result is loaded; it is taken while a finished result still waits in the
// output register.
// Registers sit on an APB-style port at byte address 8*i, 64-bit data.
`default_nettype none

`include "fixed_timestep_accumulator_defines.svh"

module fixed_timestep_accumulator
  import fta_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = AccWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] elapsed_us_i,
  input  wire logic [15:0] forced_steps_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      steps_taken_o,
  output logic [63:0]      fixed_time_us_o,
  output logic [63:0]      render_time_us_o,
  output logic [16:0]      alpha_q16_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_ACC,
    S_STEP,
    S_MULFIX,
    S_FADD,
    S_TIME,
    S_REND,
    S_DIV,
    S_DONE
  } state_e;

  // configuration
  logic [31:0] step_q;
  logic [7:0]  max_q;
  logic [31:0] scale_q;
  logic        pause_q;
  logic [63:0] epoch_q;

  // working state
  state_e               state_q;
  logic [31:0]          elapsed_q;
  logic [ACC_WIDTH-1:0] acc_q;
  logic [63:0]          fixed_q;
  logic [15:0]          cnt_q;
  logic [63:0]          prod_q;
  logic [63:0]          ftime_q;
  logic [63:0]          rtime_q;
  logic [31:0]          rem_q;
  logic [15:0]          quo_q;
  logic [3:0]           dcnt_q;
  logic [16:0]          alpha_q;

  // result register
  logic        out_valid_q;
  logic [15:0] out_steps_q;
  logic [63:0] out_fixed_q;
  logic [63:0] out_render_q;
  logic [16:0] out_alpha_q;

  logic          cfg_wr;
  reg_idx_e      cfg_idx;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;
  logic [63:0]   add_amt;
  logic [64:0]   acc_sum;
  logic [64:0]   acc_lim;
  logic          acc_ge_step;
  logic [32:0]   rem_sh;
  logic          quo_bit;
  logic          out_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_comb begin
    unique case (cfg_idx)
      REG_STEP_LENGTH: prdata = {32'd0, step_q};
      REG_MAX_STEPS:   prdata = {56'd0, max_q};
      REG_TIME_SCALE:  prdata = {32'd0, scale_q};
      REG_PAUSE:       prdata = {63'd0, pause_q};
      REG_EPOCH:       prdata = epoch_q;
      default:         prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepLengthRst;
      max_q   <= MaxStepsRst;
      scale_q <= TimeScaleRst;
      pause_q <= PauseRst;
      epoch_q <= EpochRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP_LENGTH: step_q  <= pwdata[31:0];
        REG_MAX_STEPS:   max_q   <= pwdata[7:0];
        REG_TIME_SCALE:  scale_q <= pwdata[31:0];
        REG_PAUSE:       pause_q <= pwdata[0];
        REG_EPOCH:       epoch_q <= pwdata;
        default: ;
      endcase
    end
  end

  // shared multiplier operands: elapsed * scale, or step length * step count
  always_comb begin
    if (state_q == S_SCALE) begin
      mul_a = elapsed_q;
      mul_b = scale_q;
    end else begin
      mul_a = step_q;
      mul_b = {16'd0, cnt_q};
    end
  end

  assign mul_p = mul_a * mul_b;

  // round half up, then saturating add at the accumulator width
  assign add_amt     = (prod_q + 64'h8000) >> 16;
  assign acc_sum     = {1'b0, 64'(acc_q)} + {1'b0, add_amt};
  assign acc_lim     = (65'd1 << ACC_WIDTH) - 65'd1;
  assign acc_ge_step = (acc_q >= ACC_WIDTH'(step_q));

  assign rem_sh  = {rem_q, 1'b0};
  assign quo_bit = (rem_sh >= {1'b0, step_q});

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign steps_taken_o    = out_steps_q;
  assign fixed_time_us_o  = out_fixed_q;
  assign render_time_us_o = out_render_q;
  assign alpha_q16_o      = out_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      fixed_q     <= 64'd0;
      out_valid_q <= 1'b0;
      cnt_q       <= 16'd0;
      dcnt_q      <= 4'd0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            elapsed_q <= elapsed_us_i;
            if (op_e'(operation_i) == OP_STEP) begin
              cnt_q   <= forced_steps_i;
              state_q <= S_MULFIX;
            end else begin
              state_q <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          prod_q  <= mul_p;
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (!pause_q && (scale_q != 32'd0)) begin
            if (acc_sum > acc_lim) begin
              acc_q <= '1;
            end else begin
              acc_q <= ACC_WIDTH'(acc_sum);
            end
          end
          cnt_q   <= 16'd0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          // one step per cycle; a zero step length runs to the limit
          if ((cnt_q < {8'd0, max_q}) && acc_ge_step) begin
            acc_q <= acc_q - ACC_WIDTH'(step_q);
            cnt_q <= cnt_q + 16'd1;
          end else begin
            state_q <= S_MULFIX;
          end
        end
        S_MULFIX: begin
          prod_q  <= mul_p;
          state_q <= S_FADD;
        end
        S_FADD: begin
          fixed_q <= fixed_q + prod_q;
          state_q <= S_TIME;
        end
        S_TIME: begin
          ftime_q <= epoch_q + fixed_q;
          state_q <= S_REND;
        end
        S_REND: begin
          rtime_q <= ftime_q + 64'(acc_q);
          if (step_q == 32'd0) begin
            alpha_q <= (acc_q != '0) ? AlphaOne : 17'd0;
            state_q <= S_DONE;
          end else if (acc_ge_step) begin
            alpha_q <= AlphaOne;
            state_q <= S_DONE;
          end else begin
            // acc below step here, so it fits the step width
            rem_q   <= acc_q[31:0];
            quo_q   <= 16'd0;
            dcnt_q  <= 4'd0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (quo_bit) begin
            rem_q <= 32'(rem_sh - {1'b0, step_q});
          end else begin
            rem_q <= rem_sh[31:0];
          end
          quo_q  <= {quo_q[14:0], quo_bit};
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd15) begin
            alpha_q <= {1'b0, quo_q[14:0], quo_bit};
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_steps_q  <= cnt_q;
            out_fixed_q  <= ftime_q;
            out_render_q <= rtime_q;
            out_alpha_q  <= alpha_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FTA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "busy after accept")
  `FTA_ASSERT(a_step_limit, (state_q == S_STEP) |-> (cnt_q <= {8'd0, max_q}), "steps above limit")
  `FTA_ASSERT(a_div_rem, (state_q == S_DIV) |-> (rem_q < step_q), "remainder not below step")
  `FTA_ASSERT_ALWAYS(a_alpha_range, out_valid_o |-> (alpha_q16_o <= AlphaOne), "alpha above one")

endmodule

`default_nettype wire

// File: dv/fixed_timestep_accumulator_test.sv
`default_nettype none

module fixed_timestep_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fta_pkg::*;

  localparam int          DirRows     = 21;
  localparam int          RandomItems = 750;
  localparam int          WatchLimit  = 4000;
  localparam logic [63:0] AccMax      = (64'd1 << AccWidthDef) - 64'd1;
  localparam logic [63:0] DrainMark   = 64'h1_0000_0000;

  typedef struct packed {
    logic [15:0] steps;
    logic [63:0] fixed_us;
    logic [63:0] render_us;
    logic [16:0] alpha;
  } tick_t;

  typedef struct {
    bit          wr;
    reg_idx_e    sel;
    logic [63:0] val;
    op_e         op;
    logic [31:0] elapsed;
    logic [15:0] forced;
    bit          typed;
    tick_t       want;
  } plan_row_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [5:0]  paddr          = '0;
  logic [63:0] pwdata         = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        operation_i    = 1'b0;
  logic [31:0] elapsed_us_i   = '0;
  logic [15:0] forced_steps_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] steps_taken_o;
  logic [63:0] fixed_time_us_o;
  logic [63:0] render_time_us_o;
  logic [16:0] alpha_q16_o;

  // predictor copy of the registers and the clock state
  logic [31:0] cfg_step  = StepLengthRst;
  logic [7:0]  cfg_max   = MaxStepsRst;
  logic [31:0] cfg_scale = TimeScaleRst;
  logic        cfg_pause = PauseRst;
  logic [63:0] cfg_epoch = EpochRst;
  logic [63:0] fixed_q   = '0;
  logic [63:0] acc_q     = '0;

  tick_t ticks_due[$];
  int    items_sent  = 0;
  int    mismatches  = 0;
  int    quiet_cycles = 0;
  bit    steady      = 1'b0;

  plan_row_t plan [DirRows] = '{
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_ADVANCE, 32'd0, 16'd0, 1'b1,
      '{16'd0, 64'd0, 64'd0, 17'd0}},
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_STEP, 32'd0, 16'd0, 1'b1,
      '{16'd0, 64'd0, 64'd0, 17'd0}},
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_ADVANCE, 32'd16667, 16'd0, 1'b1,
      '{16'd1, 64'd16667, 64'd16667, 17'd0}},
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_ADVANCE, 32'd32768, 16'd0, 1'b0, '0},
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_STEP, 32'd0, 16'hFFFF, 1'b0, '0},
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'd0, 1'b0, '0},
    // zero scale still drains whole steps
    '{1'b1, REG_TIME_SCALE, 64'd0, OP_ADVANCE, 32'd1000, 16'd0, 1'b0, '0},
    // half a microsecond rounds up
    '{1'b1, REG_TIME_SCALE, 64'd32768, OP_ADVANCE, 32'd1, 16'd0, 1'b0, '0},
    // accumulator saturates
    '{1'b1, REG_TIME_SCALE, 64'hFFFF_FFFF, OP_ADVANCE, 32'hFFFF_FFFF, 16'd0, 1'b0, '0},
    '{1'b1, REG_MAX_STEPS, 64'd255, OP_ADVANCE, 32'd0, 16'd0, 1'b0, '0},
    '{1'b1, REG_MAX_STEPS, 64'd0, OP_ADVANCE, 32'd5, 16'd0, 1'b0, '0},
    '{1'b1, REG_MAX_STEPS, 64'd1, OP_ADVANCE, 32'd0, 16'd0, 1'b0, '0},
    '{1'b1, REG_PAUSE, 64'd1, OP_ADVANCE, 32'hFFFF_FFFF, 16'd0, 1'b0, '0},
    // zero step length
    '{1'b1, REG_STEP_LENGTH, 64'd0, OP_ADVANCE, 32'd7, 16'd0, 1'b0, '0},
    '{1'b0, REG_STEP_LENGTH, 64'd0, OP_STEP, 32'd0, 16'd100, 1'b0, '0},
    '{1'b1, REG_PAUSE, 64'd0, OP_ADVANCE, 32'd3, 16'd0, 1'b0, '0},
    '{1'b1, REG_EPOCH, 64'h8000_0000_0000_0000, OP_STEP, 32'd0, 16'd1, 1'b0, '0},
    '{1'b1, REG_EPOCH, 64'h7FFF_FFFF_FFFF_FFFF, OP_ADVANCE, 32'd1, 16'd0, 1'b0, '0},
    '{1'b1, REG_STEP_LENGTH, 64'hFFFF_FFFF, OP_STEP, 32'd0, 16'hFFFF, 1'b0, '0},
    '{1'b1, REG_MAX_STEPS, 64'd255, OP_ADVANCE, 32'd0, 16'd0, 1'b0, '0},
    '{1'b1, REG_STEP_LENGTH, 64'd1, OP_ADVANCE, 32'hAAAA_5555, 16'h5555, 1'b0, '0}
  };

  fixed_timestep_accumulator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .elapsed_us_i    (elapsed_us_i),
    .forced_steps_i  (forced_steps_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .steps_taken_o   (steps_taken_o),
    .fixed_time_us_o (fixed_time_us_o),
    .render_time_us_o(render_time_us_o),
    .alpha_q16_o     (alpha_q16_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic tick_t predict_tick(op_e op, logic [31:0] elapsed, logic [15:0] forced);
    logic [63:0] scaled;
    logic [63:0] sum;
    logic [63:0] steps;
    logic [63:0] span;
    logic [63:0] quot;
    tick_t       r;
    if (op == OP_ADVANCE) begin
      if (!cfg_pause && cfg_scale != 0) begin
        scaled = (64'(elapsed) * 64'(cfg_scale) + 64'h8000) >> 16;
        sum = acc_q + scaled;
        if (sum > AccMax) sum = AccMax;
        acc_q = sum;
      end
      if (cfg_step == 0) begin
        steps = 64'(cfg_max);
      end else begin
        steps = acc_q / 64'(cfg_step);
        if (steps > 64'(cfg_max)) steps = 64'(cfg_max);
      end
      span = steps * 64'(cfg_step);
      acc_q = acc_q - span;
      fixed_q = fixed_q + span;
    end else begin
      steps = 64'(forced);
      fixed_q = fixed_q + 64'(cfg_step) * 64'(forced);
    end
    r.steps = steps[15:0];
    r.fixed_us = cfg_epoch + fixed_q;
    r.render_us = r.fixed_us + acc_q;
    if (cfg_step == 0) begin
      r.alpha = (acc_q != 0) ? AlphaOne : 17'd0;
    end else if (acc_q >= 64'(cfg_step)) begin
      r.alpha = AlphaOne;
    end else begin
      quot = (acc_q << 16) / 64'(cfg_step);
      r.alpha = quot[16:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(19))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: begin
        if (cfg_step == 0 || cfg_step > 32'h2000_0000) return $urandom_range(0, 100000);
        return $urandom_range(0, cfg_step * 32'd3);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_forced();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 20));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_tick();
    tick_t want;
    if (ticks_due.size() == 0) begin
      note_mismatch($sformatf("result with nothing pending, steps_taken=%0d", steps_taken_o));
      return;
    end
    want = ticks_due.pop_front();
    if (steps_taken_o !== want.steps)
      note_mismatch($sformatf("steps_taken %0d, want %0d", steps_taken_o, want.steps));
    if (fixed_time_us_o !== want.fixed_us)
      note_mismatch($sformatf("fixed_time_us %h, want %h", fixed_time_us_o, want.fixed_us));
    if (render_time_us_o !== want.render_us)
      note_mismatch($sformatf("render_time_us %h, want %h", render_time_us_o, want.render_us));
    if (alpha_q16_o !== want.alpha)
      note_mismatch($sformatf("alpha_q16 %0d, want %0d", alpha_q16_o, want.alpha));
  endtask

  // result side: random back-pressure, none during the steady stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_tick();
      out_ready_i <= steady || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e sel, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (sel)
      REG_STEP_LENGTH: cfg_step = val[31:0];
      REG_MAX_STEPS:   cfg_max = val[7:0];
      REG_TIME_SCALE:  cfg_scale = val[31:0];
      REG_PAUSE:       cfg_pause = val[0];
      REG_EPOCH:       cfg_epoch = val;
      default: ;
    endcase
  endtask

  task automatic send_item(op_e op, logic [31:0] elapsed, logic [15:0] forced, bit typed,
                           tick_t want);
    tick_t due;
    steady = (items_sent >= 300 && items_sent < 450);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    elapsed_us_i   <= elapsed;
    forced_steps_i <= forced;
    do @(posedge clk_i); while (!in_ready_o);
    due = predict_tick(op, elapsed, forced);
    ticks_due.push_back(typed ? want : due);
    items_sent++;
  endtask

  // every item returns a result, so an empty queue means the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ticks_due.size() != 0);
  endtask

  initial begin
    int  phase_len;
    op_e op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        settle();
        write_reg(plan[i].sel, plan[i].val);
      end
      send_item(plan[i].op, plan[i].elapsed, plan[i].forced, plan[i].typed, plan[i].want);
    end

    while (items_sent < DirRows + RandomItems) begin
      settle();
      if (acc_q >= DrainMark) begin
        // bleed a large leftover off with the longest steps
        write_reg(REG_STEP_LENGTH, 64'hFFFF_FFFF);
        write_reg(REG_MAX_STEPS, 64'd255);
        write_reg(REG_PAUSE, 64'd1);
        while (acc_q >= DrainMark && items_sent < DirRows + RandomItems)
          send_item(OP_ADVANCE, $urandom, 16'($urandom), 1'b0, '0);
      end else begin
        if ($urandom_range(1)) begin
          case ($urandom_range(7))
            0: write_reg(REG_STEP_LENGTH, 64'd0);
            1: write_reg(REG_STEP_LENGTH, 64'd1);
            2: write_reg(REG_STEP_LENGTH, 64'hFFFF_FFFF);
            3: write_reg(REG_STEP_LENGTH, 64'($urandom));
            default: write_reg(REG_STEP_LENGTH, 64'($urandom_range(1, 50000)));
          endcase
        end
        if ($urandom_range(1)) begin
          case ($urandom_range(5))
            0: write_reg(REG_MAX_STEPS, 64'd0);
            1: write_reg(REG_MAX_STEPS, 64'd255);
            2: write_reg(REG_MAX_STEPS, 64'($urandom_range(0, 255)));
            default: write_reg(REG_MAX_STEPS, 64'($urandom_range(1, 16)));
          endcase
        end
        if ($urandom_range(1)) begin
          case ($urandom_range(5))
            0: write_reg(REG_TIME_SCALE, 64'd0);
            1: write_reg(REG_TIME_SCALE, 64'hFFFF_FFFF);
            2: write_reg(REG_TIME_SCALE, 64'($urandom));
            default: write_reg(REG_TIME_SCALE, 64'($urandom_range(16384, 262144)));
          endcase
        end
        if ($urandom_range(1)) write_reg(REG_PAUSE, 64'($urandom_range(4) == 0));
        if ($urandom_range(1)) begin
          case ($urandom_range(3))
            0: write_reg(REG_EPOCH, 64'h8000_0000_0000_0000);
            1: write_reg(REG_EPOCH, 64'h7FFF_FFFF_FFFF_FFFF);
            default: write_reg(REG_EPOCH, {$urandom, $urandom});
          endcase
        end
        phase_len = $urandom_range(10, 60);
        repeat (phase_len) begin
          op = ($urandom_range(9) < 7) ? OP_ADVANCE : OP_STEP;
          send_item(op, pick_elapsed(), pick_forced(), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/fta_pkg.sv
sv/fixed_timestep_accumulator.sv
dv/fixed_timestep_accumulator_test.sv
